// ----- src/urb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

   // operation codes carried by a request transaction
   typedef enum logic [2:0] {
      OP_RX_BYTE    = 3'd0,
      OP_HOST_READ  = 3'd1,
      OP_WRITE_REQ  = 3'd2,
      OP_WRITE_DATA = 3'd3,
      OP_TX_READY   = 3'd4
   } op_type;

   localparam int OP_W   = 3;
   localparam int BYTE_W = 8;
   localparam int OCC_W  = 7;

   // outcome of one transaction, known before the store read completes
   typedef struct packed {
      logic             rx_popped;
      logic             rx_available;
      logic             rx_dropped;
      logic             write_accepted;
      logic             tx_valid;
      logic             tx_armed;
      logic [OCC_W-1:0] tx_occupied;
   } status_type;

endpackage

`default_nettype wire

// ----- src/urb_interfaces.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface urb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] data_byte;
   logic [7:0] write_length;

   modport source (output valid, output op, output data_byte, output write_length,
                   input ready);
   modport sink (input valid, input op, input data_byte, input write_length,
                 output ready);
endinterface

interface urb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_value;
   logic       rx_available;
   logic       rx_dropped;
   logic       write_accepted;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       tx_armed;
   logic [6:0] tx_occupied;

   modport source (output valid, output read_value, output rx_available,
                   output rx_dropped, output write_accepted, output tx_valid,
                   output tx_byte, output tx_armed, output tx_occupied,
                   input ready);
   modport sink (input valid, input read_value, input rx_available,
                 input rx_dropped, input write_accepted, input tx_valid,
                 input tx_byte, input tx_armed, input tx_occupied,
                 output ready);
endinterface

`default_nettype wire

// ----- src/uart_rx_tx_ring_buffers.sv -----
`timescale 1ns / 1ps
`default_nettype none
// flow: a taken request transaction first enters the pending stage while its ring
//    store read is registered, then its result loads into the result register
// a new request transaction is not taken while one is pending, nor while the
//    result register holds a result that the sink has not yet taken
// reset: synchronous; ring indexes, arming, pending message length and the
//    handshake state clear at once, the ring stores are not cleared

module uart_rx_tx_ring_buffers #(
   parameter int RING_DEPTH = 128
) (
   input wire logic clock,
   input wire logic reset,
   urb_req_if.sink   req_bus,
   urb_rsp_if.source rsp_bus
);
   import urb_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic             accept;
   logic             pend_ff, pend_in;
   status_type       status;
   status_type       status_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       read_value_ff, tx_byte_ff;
   status_type       rsp_status_ff;
   logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [PTR_W-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
   logic [7:0]       rx_wr_data, tx_wr_data, rx_rd_data, tx_rd_data;

   // one transaction in flight; result register must be free next cycle
   assign req_bus.ready = !pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   urb_ctrl #(
      .RING_DEPTH (RING_DEPTH),
      .PTR_W      (PTR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .op           (req_bus.op),
      .data_byte    (req_bus.data_byte),
      .write_length (req_bus.write_length),
      .rx_wr_en     (rx_wr_en),
      .rx_wr_addr   (rx_wr_addr),
      .rx_wr_data   (rx_wr_data),
      .rx_rd_en     (rx_rd_en),
      .rx_rd_addr   (rx_rd_addr),
      .tx_wr_en     (tx_wr_en),
      .tx_wr_addr   (tx_wr_addr),
      .tx_wr_data   (tx_wr_data),
      .tx_rd_en     (tx_rd_en),
      .tx_rd_addr   (tx_rd_addr),
      .status       (status)
   );

   urb_ring_ram #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (PTR_W)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (rx_wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   urb_ring_ram #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (PTR_W)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (tx_wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // pending stage waits for the store read
   assign pend_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
      end
   end

   // result register
   assign rsp_valid_in = pend_ff || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_status_ff <= status_ff;
         read_value_ff <= status_ff.rx_popped ? rx_rd_data : '0;
         tx_byte_ff    <= status_ff.tx_valid ? tx_rd_data : '0;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_value     = read_value_ff;
   assign rsp_bus.rx_available   = rsp_status_ff.rx_available;
   assign rsp_bus.rx_dropped     = rsp_status_ff.rx_dropped;
   assign rsp_bus.write_accepted = rsp_status_ff.write_accepted;
   assign rsp_bus.tx_valid       = rsp_status_ff.tx_valid;
   assign rsp_bus.tx_byte        = tx_byte_ff;
   assign rsp_bus.tx_armed       = rsp_status_ff.tx_armed;
   assign rsp_bus.tx_occupied    = rsp_status_ff.tx_occupied;

   // a taken transaction always reaches the pending stage
   assert property (@(posedge clock) disable iff (reset) accept |=> pend_ff)
      else $error("accepted transaction not pending");

   // pending result always loads into the result register
   assert property (@(posedge clock) disable iff (reset) pend_ff |=> rsp_valid_ff)
      else $error("pending result lost");

   // the result register is never overwritten while a result waits
   assert property (@(posedge clock) disable iff (reset)
                    pend_ff |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result register overwritten");

   // no new transaction while one is in flight
   assert property (@(posedge clock) disable iff (reset) pend_ff |-> !req_bus.ready)
      else $error("request taken while busy");

endmodule

`default_nettype wire

// ----- src/urb_ring_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module urb_ring_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [7:0]        rd_data
);
   import urb_pkg::*;

   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/urb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module urb_ctrl #(
   parameter int RING_DEPTH = 128,
   parameter int PTR_W      = $clog2(RING_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2:0]       op,
   input  wire logic [7:0]       data_byte,
   input  wire logic [7:0]       write_length,
   output      logic             rx_wr_en,
   output      logic [PTR_W-1:0] rx_wr_addr,
   output      logic [7:0]       rx_wr_data,
   output      logic             rx_rd_en,
   output      logic [PTR_W-1:0] rx_rd_addr,
   output      logic             tx_wr_en,
   output      logic [PTR_W-1:0] tx_wr_addr,
   output      logic [7:0]       tx_wr_data,
   output      logic             tx_rd_en,
   output      logic [PTR_W-1:0] tx_rd_addr,
   output      urb_pkg::status_type status
);
   import urb_pkg::*;

   localparam int EXT_W = (PTR_W + 1 > BYTE_W) ? PTR_W + 1 : BYTE_W;
   localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(RING_DEPTH - 1);
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(RING_DEPTH);
   localparam logic [EXT_W-1:0] CAPACITY  = EXT_W'(RING_DEPTH - 1);

   logic [PTR_W-1:0]  rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0]  tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic              armed_ff, armed_in;
   logic [BYTE_W-1:0] remain_ff, remain_in;
   logic [PTR_W-1:0]  rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
   logic [EXT_W-1:0]  tx_count_now, tx_count_next, tx_free;
   logic              popped, dropped, accepted, tx_sent;

   // queued bytes between two indexes, wrapping at the ring depth
   function automatic logic [EXT_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                   input logic [PTR_W-1:0] tail);
      logic [EXT_W-1:0] wrap;
      wrap = (head < tail) ? DEPTH_EXT : '0;
      return EXT_W'(head) + wrap - EXT_W'(tail);
   endfunction

   // index increments
   assign rx_head_inc = (rx_head_ff == LAST_IDX) ? '0 : rx_head_ff + 1'b1;
   assign rx_tail_inc = (rx_tail_ff == LAST_IDX) ? '0 : rx_tail_ff + 1'b1;
   assign tx_head_inc = (tx_head_ff == LAST_IDX) ? '0 : tx_head_ff + 1'b1;
   assign tx_tail_inc = (tx_tail_ff == LAST_IDX) ? '0 : tx_tail_ff + 1'b1;

   assign tx_count_now = ring_count(tx_head_ff, tx_tail_ff);
   assign tx_free      = CAPACITY - tx_count_now;

   // decode of one transaction
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      armed_in   = armed_ff;
      remain_in  = remain_ff;
      popped     = 1'b0;
      dropped    = 1'b0;
      accepted   = 1'b0;
      tx_sent    = 1'b0;
      case (op_type'(op))
         OP_RX_BYTE: begin
            if (rx_head_inc != rx_tail_ff) begin
               rx_head_in = rx_head_inc;
            end else begin
               dropped = 1'b1;
            end
         end
         OP_HOST_READ: begin
            if (rx_head_ff != rx_tail_ff) begin
               popped     = 1'b1;
               rx_tail_in = rx_tail_inc;
            end
         end
         OP_WRITE_REQ: begin
            if (remain_ff == '0 && EXT_W'(write_length) <= tx_free) begin
               remain_in = write_length;
               armed_in  = 1'b1;
               accepted  = 1'b1;
            end
         end
         OP_WRITE_DATA: begin
            if (remain_ff != '0 && tx_head_inc != tx_tail_ff) begin
               tx_head_in = tx_head_inc;
               remain_in  = remain_ff - 1'b1;
            end
         end
         OP_TX_READY: begin
            if (armed_ff) begin
               if (tx_head_ff == tx_tail_ff) begin
                  armed_in = 1'b0;
               end else begin
                  tx_sent    = 1'b1;
                  tx_tail_in = tx_tail_inc;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // store accesses issued with the transaction
   assign rx_wr_en   = start && (op_type'(op) == OP_RX_BYTE) && !dropped;
   assign rx_wr_addr = rx_head_ff;
   assign rx_wr_data = data_byte;
   assign rx_rd_en   = start && popped;
   assign rx_rd_addr = rx_tail_ff;
   assign tx_wr_en   = start && (tx_head_in != tx_head_ff);
   assign tx_wr_addr = tx_head_ff;
   assign tx_wr_data = data_byte;
   assign tx_rd_en   = start && tx_sent;
   assign tx_rd_addr = tx_tail_ff;

   // status after the transaction
   assign tx_count_next         = ring_count(tx_head_in, tx_tail_in);
   assign status.rx_popped      = popped;
   assign status.rx_available   = rx_head_in != rx_tail_in;
   assign status.rx_dropped     = dropped;
   assign status.write_accepted = accepted;
   assign status.tx_valid       = tx_sent;
   assign status.tx_armed       = armed_in;
   assign status.tx_occupied    = tx_count_next[OCC_W-1:0];

   // ring indexes and transmit bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
         armed_ff   <= 1'b0;
         remain_ff  <= '0;
      end else if (start) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
         armed_ff   <= armed_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/uart_rx_tx_ring_buffers_test.sv -----
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_test;
   import urb_pkg::*;

   localparam int RING_DEPTH   = 128;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 40;
   localparam int HOLD_CYCLES  = 400;

   // one expected or observed response transaction
   typedef struct packed {
      logic [BYTE_W-1:0] read_value;
      logic              rx_available;
      logic              rx_dropped;
      logic              write_accepted;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_armed;
      logic [OCC_W-1:0]  tx_occupied;
   } uart_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urb_req_if req_bus ();
   urb_rsp_if rsp_bus ();

   uart_rx_tx_ring_buffers #(
      .RING_DEPTH(RING_DEPTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // ring shadow state
   logic [BYTE_W-1:0] rx_bytes [RING_DEPTH];
   logic [BYTE_W-1:0] tx_bytes [RING_DEPTH];
   int                rx_wr = 0;
   int                rx_rd = 0;
   int                tx_wr = 0;
   int                tx_rd = 0;
   logic              tx_irq_on = 1'b0;
   int                msg_left = 0;

   uart_result_type   pending_results[$];
   uart_result_type   got_result;
   uart_result_type   want_result;
   int                mismatches = 0;
   int                items_sent = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_left = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // next state of both rings for one accepted request transaction
   function automatic uart_result_type predict_ring_step(logic [OP_W-1:0] op,
                                                         logic [BYTE_W-1:0] data,
                                                         logic [BYTE_W-1:0] len);
      uart_result_type res;
      int              free_slots;
      res = '0;
      free_slots = RING_DEPTH - 1 - ((tx_wr - tx_rd + RING_DEPTH) % RING_DEPTH);
      case (op)
         OP_RX_BYTE: begin
            if ((rx_wr + 1) % RING_DEPTH != rx_rd) begin
               rx_bytes[rx_wr] = data;
               rx_wr = (rx_wr + 1) % RING_DEPTH;
            end else begin
               res.rx_dropped = 1'b1;
            end
         end
         OP_HOST_READ: begin
            if (rx_wr != rx_rd) begin
               res.read_value = rx_bytes[rx_rd];
               rx_rd = (rx_rd + 1) % RING_DEPTH;
            end
         end
         OP_WRITE_REQ: begin
            // whole message must fit, and only one message at a time
            if (msg_left == 0 && int'(len) <= free_slots) begin
               msg_left = int'(len);
               tx_irq_on = 1'b1;
               res.write_accepted = 1'b1;
            end
         end
         OP_WRITE_DATA: begin
            if (msg_left != 0 && (tx_wr + 1) % RING_DEPTH != tx_rd) begin
               tx_bytes[tx_wr] = data;
               tx_wr = (tx_wr + 1) % RING_DEPTH;
               msg_left = msg_left - 1;
            end
         end
         OP_TX_READY: begin
            if (tx_irq_on) begin
               if (tx_wr == tx_rd) begin
                  tx_irq_on = 1'b0;
               end else begin
                  res.tx_byte = tx_bytes[tx_rd];
                  res.tx_valid = 1'b1;
                  tx_rd = (tx_rd + 1) % RING_DEPTH;
               end
            end
         end
         default: ;
      endcase
      res.rx_available = (rx_wr != rx_rd);
      res.tx_armed = tx_irq_on;
      res.tx_occupied = OCC_W'((tx_wr - tx_rd + RING_DEPTH) % RING_DEPTH);
      return res;
   endfunction

   function automatic string format_result(uart_result_type r);
      return $sformatf({"read=%02h avail=%0b drop=%0b accept=%0b tx_valid=%0b ",
                        "tx_byte=%02h armed=%0b occupied=%0d"},
                       r.read_value, r.rx_available, r.rx_dropped, r.write_accepted,
                       r.tx_valid, r.tx_byte, r.tx_armed, r.tx_occupied);
   endfunction

   // response sink: random stalls, plus a counted hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_result = '{rsp_bus.read_value, rsp_bus.rx_available, rsp_bus.rx_dropped,
                        rsp_bus.write_accepted, rsp_bus.tx_valid, rsp_bus.tx_byte,
                        rsp_bus.tx_armed, rsp_bus.tx_occupied};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: %s", format_result(got_result));
         end else begin
            want_result = pending_results.pop_front();
            if (got_result !== want_result) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("response mismatch at %0t", $realtime);
                  $display("   expected %s", format_result(want_result));
                  $display("   actual   %s", format_result(got_result));
               end
            end
         end
      end
   end

   // drive one request transaction and wait for it to be taken
   task automatic send_transaction(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                   logic [BYTE_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.data_byte    <= data;
      req_bus.write_length <= len;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_ring_step(op, data, len));
      if (op <= OP_TX_READY)
         items_sent++;
   endtask

   // release the request bus and wait for every outstanding response
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(int idle_pct, int stall);
      send_idle_pct = idle_pct;
      stall_pct = stall;
   endtask

   // field extremes, every op and the empty-ring cases of both rings
   task automatic test_directed();
      send_transaction(OP_HOST_READ, 8'h00, 8'h00);
      send_transaction(OP_RX_BYTE, 8'h00, 8'hff);
      send_transaction(OP_RX_BYTE, 8'hff, 8'h00);
      repeat (3) send_transaction(OP_HOST_READ, 8'hff, 8'hff);
      send_transaction(OP_TX_READY, 8'h00, 8'h00);
      // zero-length message arms, then an empty ring disarms
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd0);
      send_transaction(OP_TX_READY, 8'hff, 8'hff);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd128);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd255);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd2);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd1);
      send_transaction(OP_WRITE_DATA, 8'hff, 8'h00);
      send_transaction(OP_WRITE_DATA, 8'h00, 8'hff);
      send_transaction(OP_WRITE_DATA, 8'h5a, 8'h00);
      repeat (3) send_transaction(OP_TX_READY, 8'h00, 8'h00);
      send_transaction(OP_TX_READY, 8'h00, 8'h00);
      // unused op codes only report status
      send_transaction(OP_W'(5), 8'hff, 8'hff);
      send_transaction(OP_W'(6), 8'h00, 8'h00);
      send_transaction(OP_W'(7), 8'hff, 8'hff);
      wait_drained();
   endtask

   // fill the receive ring past capacity, then read it empty and once more
   task automatic test_rx_ring_full();
      repeat (RING_DEPTH + 1) send_transaction(OP_RX_BYTE, BYTE_W'($urandom), 8'h00);
      repeat (RING_DEPTH) send_transaction(OP_HOST_READ, 8'h00, 8'h00);
      wait_drained();
   endtask

   // largest message fills the transmit ring, then surplus data and requests
   task automatic test_tx_ring_full();
      send_transaction(OP_WRITE_REQ, 8'h00, BYTE_W'(RING_DEPTH - 1));
      repeat (RING_DEPTH - 1) send_transaction(OP_WRITE_DATA, BYTE_W'($urandom), 8'h00);
      send_transaction(OP_WRITE_DATA, 8'hc3, 8'h00);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd1);
      send_transaction(OP_WRITE_REQ, 8'h00, 8'd0);
      repeat (RING_DEPTH + 1) send_transaction(OP_TX_READY, 8'h00, 8'h00);
      wait_drained();
   endtask

   // mostly well-formed message and byte sequences with random content
   task automatic run_random_traffic(int count);
      int goal;
      int kind;
      int len;
      int num;
      goal = items_sent + count;
      while (items_sent < goal) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            num = ($urandom_range(9) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 12);
            repeat (num) send_transaction(OP_RX_BYTE, BYTE_W'($urandom), BYTE_W'($urandom));
         end else if (kind < 35) begin
            num = ($urandom_range(9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 12);
            repeat (num) send_transaction(OP_HOST_READ, BYTE_W'($urandom), BYTE_W'($urandom));
         end else if (kind < 75) begin
            num = $urandom_range(99);
            if (num < 60)
               len = $urandom_range(0, 16);
            else if (num < 85)
               len = $urandom_range(17, RING_DEPTH - 1);
            else
               len = $urandom_range(0, 255);
            send_transaction(OP_WRITE_REQ, BYTE_W'($urandom), BYTE_W'(len));
            // short or overlong message bodies now and then
            num = ($urandom_range(4) == 0) ? $urandom_range(0, len + 3) : len;
            repeat (num) send_transaction(OP_WRITE_DATA, BYTE_W'($urandom), BYTE_W'($urandom));
            if ($urandom_range(1) == 1)
               repeat ($urandom_range(0, len + 2))
                  send_transaction(OP_TX_READY, BYTE_W'($urandom), BYTE_W'($urandom));
         end else if (kind < 90) begin
            num = ($urandom_range(9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 20);
            repeat (num) send_transaction(OP_TX_READY, BYTE_W'($urandom), BYTE_W'($urandom));
         end else begin
            send_transaction(OP_W'($urandom_range(7)), BYTE_W'($urandom), BYTE_W'($urandom));
         end
      end
   endtask

   task automatic test_random_phases();
      set_idling(0, 0);
      run_random_traffic(PHASE_ITEMS);
      wait_drained();
      set_idling(77, 0);
      run_random_traffic(PHASE_ITEMS);
      wait_drained();
      set_idling(0, 77);
      run_random_traffic(PHASE_ITEMS);
      wait_drained();
      set_idling(32, 32);
      run_random_traffic(PHASE_ITEMS);
      wait_drained();
   endtask

   // long sink hold-off while requests keep coming, then a drain and random op codes
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_left = HOLD_CYCLES;
      repeat (30) send_transaction(OP_RX_BYTE, BYTE_W'($urandom), BYTE_W'($urandom));
      repeat (30) send_transaction(OP_W'($urandom_range(OP_HOST_READ, OP_TX_READY)),
                                   BYTE_W'($urandom), BYTE_W'($urandom));
      wait_drained();
      repeat (20) send_transaction(OP_W'($urandom_range(7)), BYTE_W'($urandom),
                                   BYTE_W'($urandom));
      wait_drained();
   endtask

   // sequence of tests
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_RX_BYTE;
      req_bus.data_byte    = '0;
      req_bus.write_length = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_rx_ring_full();
      test_tx_ring_full();
      test_random_phases();
      test_backpressure();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
